// ===== design/rgb_fade_contrast_shade_assert.svh =====
// ----------------------------------------------------------------------------
// rgb_fade_contrast_shade assertion macros
// Clocked on clk, quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef RGB_FADE_CONTRAST_SHADE_ASSERT_SVH
`define RGB_FADE_CONTRAST_SHADE_ASSERT_SVH

// hold cons in the same cycle as ante
`define RFCS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rfcs: check failed");

// hold cons after ante, delayed by n
`define RFCS_ASSERT_LATENCY(lbl, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("rfcs: latency check failed");

`endif

// ===== design/rfcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rfcs_pkg
// Types, constants and arithmetic helpers of the fade-and-shade pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfcs_pkg;

	localparam int unsigned FADE_FRAC_BITS = 8;
	localparam int unsigned CHAN_W         = 8;
	localparam int unsigned FADE_W         = 9;
	localparam int unsigned PIX_W          = 3 * CHAN_W;
	localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

	// integer square root of fade * ONE
	localparam int unsigned SQ_IN_W   = FADE_W + FADE_FRAC_BITS;
	localparam int unsigned SQ_K      = (SQ_IN_W + 1) / 2;
	localparam int unsigned SQ_V_W    = 2 * SQ_K;
	localparam int unsigned SQ_R_W    = SQ_K + 2;
	localparam int unsigned SQ_STAGES = 3;
	localparam int unsigned SQ_IPS    = (SQ_K + SQ_STAGES - 1) / SQ_STAGES;

	// channel compare and subtract width
	localparam int unsigned CMP_W = ((CHAN_W + FADE_FRAC_BITS > FADE_W + CHAN_W) ?
		CHAN_W + FADE_FRAC_BITS : FADE_W + CHAN_W) + 1;

	// channel times root
	localparam int unsigned PROD_W = CHAN_W + SQ_K;

	// floor(x*85/100) as floor(x * 85 * 5243 / 2^19), exact for x <= 255
	localparam int unsigned SCALE_MUL    = 85 * 5243;
	localparam int unsigned SCALE_SHIFT  = 19;
	localparam int unsigned SCALE_PROD_W = 27;
	localparam logic [CHAN_W-1:0] SHADE_MAX = CHAN_W'(255 * 85 / 100);

	typedef logic [2:0][CHAN_W-1:0] chan3_t;

	typedef struct packed {
		logic [SQ_V_W-1:0] v;
		logic [SQ_R_W-1:0] r;
		logic [SQ_K-1:0]   q;
	} sq_t;

	typedef struct packed {
		logic              sel;
		logic [CHAN_W-1:0] val;
	} prep_t;

	function automatic sq_t sq_init(logic [FADE_W-1:0] f);
		sq_t b;
		b.v = SQ_V_W'({f, {FADE_FRAC_BITS{1'b0}}});
		b.r = '0;
		b.q = '0;
		return b;
	endfunction

	function automatic sq_t sq_step(sq_t a);
		logic [SQ_R_W+1:0] wide;
		logic [SQ_R_W+1:0] trial;
		sq_t b;
		wide  = {a.r, a.v[SQ_V_W-1 -: 2]};
		trial = (SQ_R_W + 2)'({a.q, 2'b01});
		b.v   = a.v << 2;
		if (wide >= trial) begin
			b.r = SQ_R_W'(wide - trial);
			b.q = {a.q[SQ_K-2:0], 1'b1};
		end else begin
			b.r = SQ_R_W'(wide);
			b.q = {a.q[SQ_K-2:0], 1'b0};
		end
		return b;
	endfunction

	function automatic sq_t sq_run(sq_t a, int unsigned base);
		sq_t b;
		b = a;
		for (int unsigned j = 0; j < SQ_IPS; j++) begin
			if (base + j < SQ_K) begin
				b = sq_step(b);
			end
		end
		return b;
	endfunction

	function automatic prep_t chan_prep(logic [CHAN_W-1:0] c, logic [FADE_W-1:0] f);
		logic [CMP_W-1:0] lhs;
		logic [CMP_W-1:0] f_max;
		logic [CMP_W-1:0] f_rest;
		logic [CMP_W-1:0] diff;
		prep_t p;
		lhs    = CMP_W'(c) << FADE_FRAC_BITS;
		f_max  = CMP_W'(f) * CMP_W'(CHAN_MAX);
		f_rest = CMP_W'(f) * CMP_W'(CHAN_MAX - c);
		diff   = lhs - f_rest;
		p.sel  = (lhs > f_max);
		p.val  = CHAN_W'(diff >> FADE_FRAC_BITS);
		return p;
	endfunction

	function automatic logic [CHAN_W-1:0] root_shade(logic [CHAN_W-1:0] c, logic [SQ_K-1:0] q);
		logic [PROD_W-1:0] p;
		logic [PROD_W-1:0] x;
		p = PROD_W'(c) * PROD_W'(q);
		x = p >> FADE_FRAC_BITS;
		return (x > PROD_W'(CHAN_MAX)) ? CHAN_MAX : CHAN_W'(x);
	endfunction

	function automatic logic [CHAN_W-1:0] scale85(logic [CHAN_W-1:0] x);
		logic [SCALE_PROD_W-1:0] y;
		y = SCALE_PROD_W'(x) * SCALE_PROD_W'(SCALE_MUL);
		return CHAN_W'(y >> SCALE_SHIFT);
	endfunction

endpackage

`default_nettype wire

// ===== design/rgb_fade_contrast_shade.sv =====
// ----------------------------------------------------------------------------
// rgb_fade_contrast_shade
// Contrast-preserving fade of one 24-bit RGB pixel, then 0.85 shade.
// ----------------------------------------------------------------------------
// A pixel is taken at every clock edge where start is high; busy is tied
// low, so one pixel per clock is sustained without gaps. Each result shows
// on shaded_rgb with done high for exactly one cycle, in input order. The
// pipeline has three stages that share out the bit-by-bit square root of
// the fade factor, plus one stage for channel preparation, one for the root
// product and one for the shade.
// The receiver cannot hold results off: take each beat when done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_fade_contrast_shade (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [rfcs_pkg::PIX_W-1:0]    pixel_rgb,
	input  wire logic [rfcs_pkg::FADE_W-1:0]   fade_q8,
	output logic                               done,
	output logic [rfcs_pkg::PIX_W-1:0]         shaded_rgb
);

	import rfcs_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	chan3_t            chan_s1, chan_s2, chan_s3, chan_s4;
	chan3_t            sub_s1, sub_s2, sub_s3, sub_s4;
	logic [2:0]        sel_s1, sel_s2, sel_s3, sel_s4;
	sq_t               sq_s1, sq_s2, sq_s3, sq_s4;
	logic [FADE_W-1:0] f_s1, f_s2, f_s3, f_s4;
	chan3_t            x_s5;
	chan3_t            rgb_s6;

	assign busy = 1'b0;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		prep_t p;
		chan_s1 <= pixel_rgb;
		f_s1    <= fade_q8;
		sq_s1   <= sq_init(fade_q8);
		for (int i = 0; i < 3; i++) begin
			p          = chan_prep(pixel_rgb[i*CHAN_W +: CHAN_W], fade_q8);
			sel_s1[i] <= p.sel;
			sub_s1[i] <= p.val;
		end

		chan_s2 <= chan_s1;
		sub_s2  <= sub_s1;
		sel_s2  <= sel_s1;
		f_s2    <= f_s1;
		sq_s2   <= sq_run(sq_s1, 0);

		chan_s3 <= chan_s2;
		sub_s3  <= sub_s2;
		sel_s3  <= sel_s2;
		f_s3    <= f_s2;
		sq_s3   <= sq_run(sq_s2, SQ_IPS);

		chan_s4 <= chan_s3;
		sub_s4  <= sub_s3;
		sel_s4  <= sel_s3;
		f_s4    <= f_s3;
		sq_s4   <= sq_run(sq_s3, 2 * SQ_IPS);

		for (int i = 0; i < 3; i++) begin
			x_s5[i]   <= sel_s4[i] ? sub_s4[i] : root_shade(chan_s4[i], sq_s4.q);
			rgb_s6[i] <= scale85(x_s5[i]);
		end
	end

	assign done       = vld_s6;
	assign shaded_rgb = rgb_s6;

	// root bounds: q*q <= f*ONE < (q+1)*(q+1)
	logic [SQ_K:0]       root_up;
	logic [2*SQ_K+1:0]   rad, root_lo, root_hi;

	assign root_up = (SQ_K + 1)'(sq_s4.q) + (SQ_K + 1)'(1);
	assign rad     = (2 * SQ_K + 2)'(f_s4) << FADE_FRAC_BITS;
	assign root_lo = (2 * SQ_K + 2)'(sq_s4.q) * (2 * SQ_K + 2)'(sq_s4.q);
	assign root_hi = (2 * SQ_K + 2)'(root_up) * (2 * SQ_K + 2)'(root_up);

`include "rgb_fade_contrast_shade_assert.svh"

	`RFCS_ASSERT_LATENCY(a_beat_latency, vld_s1, 5, done)
	`RFCS_ASSERT_IMPL(a_root_bounds, vld_s4, (root_lo <= rad) && (root_hi > rad))
	`RFCS_ASSERT_IMPL(a_sub_not_above_chan, vld_s1 && sel_s1[2], sub_s1[2] <= chan_s1[2])
	`RFCS_ASSERT_IMPL(a_shade_ceiling, done, (rgb_s6[2] <= SHADE_MAX) && (rgb_s6[1] <= SHADE_MAX) && (rgb_s6[0] <= SHADE_MAX))

endmodule

`default_nettype wire

// ===== tb/sv/rgb_fade_contrast_shade_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_fade_contrast_shade_tb
// Self-checking bench for the fade-and-shade pixel pipeline. A driver sends
// pixel and fade beats from a queue, with random gaps and one gap-free
// stretch. Each accepted beat is shaded by a local predictor, and the
// expected colour is queued. A monitor takes each done beat and compares
// it with the oldest expected colour. The directed part covers the fade
// extremes, zero fade, fades above one and the compare boundary. The random
// part mixes edge channel values with uniform ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_fade_contrast_shade_tb;

	localparam int unsigned FRAC      = rfcs_pkg::FADE_FRAC_BITS;
	localparam int unsigned FADE_ONE  = 1 << FRAC;
	localparam int unsigned CHAN_TOP  = 255;
	localparam int unsigned N_RANDOM  = 530;
	localparam int unsigned DRAIN_CYC = 20;

	typedef struct {
		logic [rfcs_pkg::PIX_W-1:0]  pixel;
		logic [rfcs_pkg::FADE_W-1:0] fade;
	} px_beat_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [rfcs_pkg::PIX_W-1:0]  pixel_rgb = '0;
	logic [rfcs_pkg::FADE_W-1:0] fade_q8 = '0;
	logic                        done;
	logic [rfcs_pkg::PIX_W-1:0]  shaded_rgb;

	px_beat_t                   pixel_q[$];
	logic [rfcs_pkg::PIX_W-1:0] shade_exp_q[$];
	int unsigned                beats_taken = 0;
	int unsigned                bad_count = 0;

	rgb_fade_contrast_shade dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pixel_rgb  (pixel_rgb),
		.fade_q8    (fade_q8),
		.done       (done),
		.shaded_rgb (shaded_rgb)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int unsigned fade_root(input int unsigned v);
		int unsigned r;
		r = 0;
		while ((r + 1) * (r + 1) <= v)
			r++;
		return r;
	endfunction

	function automatic int unsigned shade_chan(input int unsigned c, input int unsigned f,
		input int unsigned s);
		int unsigned x;
		if (c * FADE_ONE > f * CHAN_TOP)
			x = (c * FADE_ONE - f * (CHAN_TOP - c)) >> FRAC;
		else
			x = (c * s) >> FRAC;
		if (x > CHAN_TOP)
			x = CHAN_TOP;
		return (x * 85) / 100;
	endfunction

	function automatic logic [rfcs_pkg::PIX_W-1:0] shade_pixel(
		input logic [rfcs_pkg::PIX_W-1:0] pix, input logic [rfcs_pkg::FADE_W-1:0] f);
		int unsigned s;
		logic [7:0] r, g, b;
		s = fade_root(int'(f) << FRAC);
		r = 8'(shade_chan(pix[23:16], f, s));
		g = 8'(shade_chan(pix[15:8], f, s));
		b = 8'(shade_chan(pix[7:0], f, s));
		return {r, g, b};
	endfunction

	function automatic logic [7:0] pick_chan();
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 5))
				0: return 8'h00;
				1: return 8'h01;
				2: return 8'h7F;
				3: return 8'h80;
				4: return 8'hFE;
				default: return 8'hFF;
			endcase
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [rfcs_pkg::FADE_W-1:0] pick_fade();
		case ($urandom_range(0, 9))
			6: begin
				case ($urandom_range(0, 4))
					0: return 9'd0;
					1: return 9'd1;
					2: return 9'd2;
					3: return 9'd255;
					default: return 9'd256;
				endcase
			end
			7, 8: return 9'($urandom_range(257, 511));
			9: return 9'($urandom_range(0, 15));
			default: return 9'($urandom_range(0, 256));
		endcase
	endfunction

	task automatic add_beat(input logic [rfcs_pkg::PIX_W-1:0] pix,
		input logic [rfcs_pkg::FADE_W-1:0] f);
		px_beat_t b;
		b.pixel = pix;
		b.fade  = f;
		pixel_q.push_back(b);
	endtask

	task automatic fault(input string what, input logic [rfcs_pkg::PIX_W-1:0] want,
		input logic [rfcs_pkg::PIX_W-1:0] got);
		bad_count++;
		if (bad_count <= 10)
			$display("%0t %s: shaded_rgb expected %06h got %06h", $realtime, what, want, got);
	endtask

	// driver: hold a beat while busy, otherwise advance or idle
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				shade_exp_q.push_back(shade_pixel(pixel_rgb, fade_q8));
				void'(pixel_q.pop_front());
				beats_taken++;
			end
			if (!(start && busy)) begin
				if (pixel_q.size() != 0 && ((beats_taken >= 200 && beats_taken < 330) ||
					$urandom_range(0, 99) >= 10)) begin
					start     <= 1'b1;
					pixel_rgb <= pixel_q[0].pixel;
					fade_q8   <= pixel_q[0].fade;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: take every done beat
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (shade_exp_q.size() == 0)
				fault("unexpected beat", 'x, shaded_rgb);
			else if (shaded_rgb !== shade_exp_q[0])
				fault("mismatch", shade_exp_q[0], shaded_rgb);
			if (shade_exp_q.size() != 0)
				void'(shade_exp_q.pop_front());
		end
	end

	initial begin
		#2ms;
		$display("rgb_fade_contrast_shade verification failed");
		$finish;
	end

	initial begin
		logic [rfcs_pkg::PIX_W-1:0]  dir_pix[3];
		logic [rfcs_pkg::FADE_W-1:0] dir_fade[7];
		dir_pix  = '{24'h000000, 24'hFFFFFF, 24'h80FF01};
		dir_fade = '{9'd0, 9'd1, 9'd128, 9'd255, 9'd256, 9'd257, 9'd511};
		foreach (dir_fade[i])
			foreach (dir_pix[j])
				add_beat(dir_pix[j], dir_fade[i]);
		add_beat(24'h7F807F, 9'd256);
		add_beat(24'hFE01FF, 9'd384);
		for (int i = 0; i < N_RANDOM; i++)
			add_beat({pick_chan(), pick_chan(), pick_chan()}, pick_fade());

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pixel_q.size() != 0 || shade_exp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (bad_count == 0)
			$display("rgb_fade_contrast_shade verification clean");
		else
			$display("rgb_fade_contrast_shade verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+design
design/rfcs_pkg.sv
design/rgb_fade_contrast_shade.sv
tb/sv/rgb_fade_contrast_shade_tb.sv
